@@ hdl/fskt_pkg.sv @@
// Shared types, codes and fingerprint hash for the fingerprint slot key table.
`default_nettype none
package fskt_pkg;
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_LOOKUP = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EXISTS  = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Request as it travels down the cell row.
  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key;
    logic [63:0] data;
    logic [7:0]  fp;
  } req_t;

  // Search status carried along the row with the request.
  typedef struct packed {
    logic        hit;
    logic        free;
    logic [7:0]  hit_idx;
    logic [7:0]  free_idx;
    logic [63:0] hit_val;
    logic [8:0]  count;
  } srch_t;

  // Write command broadcast back to the cells.
  typedef struct packed {
    logic        en;
    logic        set_valid;
    logic        clr_valid;
    logic        wr_entry;
    logic        wr_val;
    logic [7:0]  idx;
  } wcmd_t;

  function automatic logic [63:0] hash_a(input logic [63:0] k);
    logic [63:0] t;
    t = (~k) + (k << 18);
    t = t ^ (t >> 31);
    t = t + (t << 2) + (t << 4);
    return t;
  endfunction

  function automatic logic [7:0] hash_b(input logic [63:0] k);
    logic [63:0] t;
    t = k ^ (k >> 11);
    t = t + (t << 6);
    t = t ^ (t >> 22);
    return t[7:0];
  endfunction
endpackage
`default_nettype wire

@@ hdl/fskt_cell.sv @@
// One slot cell: holds valid, fingerprint, key and value, updates the passing search.
`default_nettype none
module fskt_cell import fskt_pkg::*; #(
  parameter logic [7:0] Idx = 8'd0
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  vld_i,
  input  wire req_t  req_i,
  input  wire srch_t srch_i,
  input  wire wcmd_t wcmd_i,
  output logic       vld_o,
  output req_t       req_o,
  output srch_t      srch_o
);
  logic        valid_q;
  logic [7:0]  fp_q;
  logic [63:0] key_q, val_q;
  logic        match;
  srch_t       srch_d;

  assign match = valid_q && fp_q == req_i.fp && key_q == req_i.key;

  always_comb begin
    srch_d = srch_i;
    if (valid_q) srch_d.count = srch_i.count + 9'd1;
    if (match && !srch_i.hit) begin
      srch_d.hit     = 1'b1;
      srch_d.hit_idx = Idx;
      srch_d.hit_val = val_q;
    end
    if (!valid_q && !srch_i.free) begin
      srch_d.free     = 1'b1;
      srch_d.free_idx = Idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      vld_o   <= 1'b0;
    end else begin
      vld_o <= vld_i;
      if (wcmd_i.en && wcmd_i.idx == Idx) begin
        if (wcmd_i.set_valid) valid_q <= 1'b1;
        if (wcmd_i.clr_valid) valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_o  <= req_i;
    srch_o <= srch_d;
    if (wcmd_i.en && wcmd_i.idx == Idx) begin
      if (wcmd_i.wr_entry) begin
        fp_q  <= req_i.fp;
        key_q <= req_i.key;
      end
      if (wcmd_i.wr_val) val_q <= req_i.data;
    end
  end
endmodule
`default_nettype wire

@@ hdl/fingerprint_slot_key_table.sv @@
// Top level of the fingerprint slot key table: hash stages, cell row, writeback and output.
//
//  channel | dir | handshake            | payload
//  s_axis  | in  | tvalid/tready        | tdata: mode, key, data_in
//  m_axis  | out | tvalid/tready        | tdata: status, slot, data_out, occupancy
//
// One request at a time: hash states S_H1 and S_H2, the pass through the cell row, then
// the result register loads. A writeback state S_WB follows before the next request is
// accepted. Reset clears valid bits and control. A held result stalls the next request at
// the row end until the result is taken.
`default_nettype none
module fingerprint_slot_key_table import fskt_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,  // mode[1:0], key[65:2], data_in[129:66], zeros
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [79:0]       m_axis_tdata   // status[1:0], slot[7:2], data_out[71:8], occupancy[78:72], zero
);
  localparam logic [2:0] S_IDLE = 3'd0, S_H1 = 3'd1, S_H2 = 3'd2, S_ROW = 3'd3,
                         S_WB = 3'd4;

  logic [2:0]  state_q;
  req_t        req_q;
  logic [63:0] hmid_q;
  logic        start_q;
  logic        row_done_q;
  logic        row_end;

  logic  vld   [SLOTS+1];
  req_t  rq    [SLOTS+1];
  srch_t sr    [SLOTS+1];
  wcmd_t wcmd;

  logic        out_v_q;
  logic [79:0] out_q;

  srch_t end_s;
  req_t  end_r;
  logic  res_ok;
  logic [1:0] st;
  logic [7:0] slot8;
  logic [63:0] dout;
  logic [8:0]  occ;

  assign s_axis_tready = (state_q == S_IDLE) && !start_q;

  // row result stays put once it has arrived
  assign row_end = vld[SLOTS] || row_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) state_q <= S_H1;
        S_H1:   state_q <= S_H2;
        S_H2:   begin state_q <= S_ROW; start_q <= 1'b1; end
        S_ROW:  if (row_end && (!out_v_q || m_axis_tready)) state_q <= S_WB;
        S_WB:   state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_done_q <= 1'b0;
    end else begin
      if (state_q == S_WB) row_done_q <= 1'b0;
      else if (vld[SLOTS]) row_done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      req_q.mode <= s_axis_tdata[1:0];
      req_q.key  <= s_axis_tdata[65:2];
      req_q.data <= s_axis_tdata[129:66];
    end
    if (state_q == S_H1) hmid_q <= hash_a(req_q.key);
    if (state_q == S_H2) req_q.fp <= hash_b(hmid_q);
  end

  assign vld[0] = start_q;
  assign rq[0]  = req_q;
  assign sr[0]  = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    fskt_cell #(.Idx(8'(g))) u_cell (
      .clk_i, .rst_ni,
      .vld_i(vld[g]), .req_i(rq[g]), .srch_i(sr[g]), .wcmd_i(wcmd),
      .vld_o(vld[g+1]), .req_o(rq[g+1]), .srch_o(sr[g+1])
    );
  end

  // result at end of row; the row output holds since only one request is in flight
  assign end_s = sr[SLOTS];
  assign end_r = rq[SLOTS];

  always_comb begin
    st = ST_OK; slot8 = '0; dout = '0; occ = end_s.count; res_ok = 1'b0;
    wcmd = '0;
    wcmd.en = (state_q == S_WB);
    wcmd.idx = end_s.hit_idx;
    if (end_r.mode == MODE_INSERT) begin
      if (end_s.hit) begin
        st = ST_EXISTS; slot8 = end_s.hit_idx;
      end else if (!end_s.free) begin
        st = ST_FULL;
      end else begin
        slot8 = end_s.free_idx; occ = end_s.count + 9'd1; res_ok = 1'b1;
        wcmd.idx = end_s.free_idx; wcmd.set_valid = 1'b1;
        wcmd.wr_entry = 1'b1; wcmd.wr_val = 1'b1;
      end
    end else if (!end_s.hit) begin
      st = ST_MISSING;
    end else begin
      slot8 = end_s.hit_idx;
      case (end_r.mode)
        MODE_UPDATE: wcmd.wr_val = 1'b1;
        MODE_REMOVE: begin wcmd.clr_valid = 1'b1; occ = end_s.count - 9'd1; end
        default:     dout = end_s.hit_val;
      endcase
    end
  end

  // write command must reach the request data still held at the row input
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      if (state_q == S_ROW && row_end && (!out_v_q || m_axis_tready)) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_ROW && row_end && (!out_v_q || m_axis_tready))
      out_q <= {1'b0, occ[6:0], dout, slot8[5:0], st};
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("accept while busy");
  a_wb_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WB |-> $past(state_q) == S_ROW) else $error("writeback without row result");
  a_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[SLOTS] |-> end_s.count <= 9'(SLOTS)) else $error("count overflow");
  a_res_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[SLOTS] && res_ok |-> !end_s.hit) else $error("insert over hit");
endmodule
`default_nettype wire

@@ sim/fingerprint_slot_key_table_tb.sv @@
// Testbench for the fingerprint slot key table: directed and random requests checked against a predictor.
`default_nettype none
module fingerprint_slot_key_table_tb;
  import fskt_pkg::*;

  localparam int NSLOT = 64;
  localparam int CYCLE_LIMIT = 900000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [79:0]  m_axis_tdata;

  typedef struct packed {
    logic [6:0]  occupancy;
    logic [63:0] data_out;
    logic [5:0]  slot;
    logic [1:0]  status;
  } reply_t;

  logic        tbl_valid [NSLOT];
  logic [7:0]  tbl_fp    [NSLOT];
  logic [63:0] tbl_key   [NSLOT];
  logic [63:0] tbl_val   [NSLOT];
  logic [63:0] key_pool  [$];

  reply_t replies_due[$];
  int     fail_count;
  int     cycle_count;
  logic   sink_stall_en;

  fingerprint_slot_key_table #(.SLOTS(NSLOT)) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [7:0] key_fingerprint(input logic [63:0] k);
    logic [63:0] t;
    t = (~k) + (k << 18);
    t = t ^ (t >> 31);
    t = t + (t << 2) + (t << 4);
    t = t ^ (t >> 11);
    t = t + (t << 6);
    t = t ^ (t >> 22);
    return t[7:0];
  endfunction

  function automatic reply_t apply_request(input logic [1:0] mode, input logic [63:0] k,
                                           input logic [63:0] d);
    reply_t r;
    logic [7:0] fp;
    int hit;
    int free;
    int n;
    fp = key_fingerprint(k);
    hit = -1;
    free = -1;
    r = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (hit < 0 && tbl_valid[i] && tbl_fp[i] == fp && tbl_key[i] == k) hit = i;
      if (free < 0 && !tbl_valid[i]) free = i;
    end
    if (mode == MODE_INSERT) begin
      if (hit >= 0) begin
        r.status = ST_EXISTS;
        r.slot = hit[5:0];
      end else if (free < 0) begin
        r.status = ST_FULL;
      end else begin
        tbl_valid[free] = 1'b1;
        tbl_fp[free] = fp;
        tbl_key[free] = k;
        tbl_val[free] = d;
        r.slot = free[5:0];
      end
    end else if (hit < 0) begin
      r.status = ST_MISSING;
    end else begin
      r.slot = hit[5:0];
      if (mode == MODE_UPDATE) tbl_val[hit] = d;
      else if (mode == MODE_REMOVE) tbl_valid[hit] = 1'b0;
      else r.data_out = tbl_val[hit];
    end
    n = 0;
    for (int i = 0; i < NSLOT; i++) n += tbl_valid[i];
    r.occupancy = n[6:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  task automatic source_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_request(input logic [1:0] mode, input logic [63:0] k,
                              input logic [63:0] d);
    source_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, d, k, mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    replies_due = {replies_due, apply_request(mode, k, d)};
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(0, 4) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return rand64();
  endfunction

  // reply sink with random stall
  always @(posedge clk_i) begin
    reply_t got;
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[78:0];
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected result", got.data_out, 64'd0);
      end else begin
        want = replies_due.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.slot !== want.slot)
          report_mismatch("slot", 64'(got.slot), 64'(want.slot));
        if (got.data_out !== want.data_out)
          report_mismatch("data_out", got.data_out, want.data_out);
        if (got.occupancy !== want.occupancy)
          report_mismatch("occupancy", 64'(got.occupancy), 64'(want.occupancy));
      end
    end
    if (sink_stall_en && $urandom_range(0, 3) == 0)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_edges();
    send_request(MODE_LOOKUP, 64'h0, 64'h0);
    send_request(MODE_UPDATE, 64'h0, 64'h1);
    send_request(MODE_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_request(MODE_INSERT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_request(MODE_INSERT, 64'h0, 64'h5);
    send_request(MODE_LOOKUP, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(MODE_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hA5A5_5A5A_FFFF_0000);
    send_request(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_request(MODE_REMOVE, 64'h0, 64'h0);
    send_request(MODE_LOOKUP, 64'h0, 64'h0);
    send_request(MODE_INSERT, 64'h8000_0000_0000_0001, 64'h1234);
    key_pool = {key_pool, 64'h0};
    key_pool = {key_pool, 64'hFFFF_FFFF_FFFF_FFFF};
    key_pool = {key_pool, 64'h8000_0000_0000_0001};
  endtask

  // fill to capacity, hit full, then remove up to 40 keys
  task automatic test_full_table();
    logic [63:0] k;
    for (int i = 0; i < NSLOT + 3; i++) begin
      k = rand64();
      key_pool = {key_pool, k};
      send_request(MODE_INSERT, k, rand64());
    end
    send_request(MODE_INSERT, key_pool[$], 64'h0);
    for (int i = 0; i < 40; i++) send_request(MODE_REMOVE, pick_key(), 64'h0);
  endtask

  task automatic test_random(input int count);
    logic [1:0] mode;
    for (int i = 0; i < count; i++) begin
      mode = 2'($urandom_range(0, 3));
      if (mode == MODE_INSERT && key_pool.size() < 200 && $urandom_range(0, 1) == 0)
        key_pool = {key_pool, rand64()};
      sink_stall_en <= (i % 300) < 200;
      send_request(mode, pick_key(), rand64());
    end
  endtask

  initial begin
    int guard;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    sink_stall_en = 1'b1;
    fail_count = 0;
    cycle_count = 0;
    for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edges();
    test_full_table();
    test_random(1750);
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (replies_due.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (NSLOT + 20) @(posedge clk_i);
    if (fail_count == 0 && replies_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ fingerprint_slot_key_table.f @@
hdl/fskt_pkg.sv
hdl/fskt_cell.sv
hdl/fingerprint_slot_key_table.sv
sim/fingerprint_slot_key_table_tb.sv
